// ===== hw/rtl/hrhp_pkg.sv =====
package hrhp_pkg;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_METHOD  = 4'd0,
        PH_URI     = 4'd1,
        PH_VER     = 4'd2,
        PH_VREST   = 4'd3,
        PH_HNAME   = 4'd4,
        PH_SKIP    = 4'd5,
        PH_CONN    = 4'd6,
        PH_TYPE    = 4'd7,
        PH_LEN     = 4'd8,
        PH_DISCARD = 4'd9
    } t_phase;

    // Summary status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_METH  = 3'd1;
    localparam logic [2:0] ST_TRUNC     = 3'd2;
    localparam logic [2:0] ST_URI_LONG  = 3'd3;
    localparam logic [2:0] ST_BAD_VER   = 3'd4;
    localparam logic [2:0] ST_LEN_OVF   = 3'd5;
    localparam logic [2:0] ST_POST_TYPE = 3'd6;

    localparam logic [2:0] M_POST = 3'd2;
    localparam logic [3:0] CT_NONE  = 4'd0;
    localparam logic [3:0] CT_OTHER = 4'd8;

    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;

    // Character of a string at a position, zero past its end.
    function automatic logic [7:0] str_char(input logic [8*32-1:0] s, input int len,
                                            input logic [4:0] p);
        logic [7:0] c;
        c = 8'h00;
        if (int'(p) < len) c = s[8*(len-1-int'(p)) +: 8];
        return c;
    endfunction

    function automatic logic [7:0] meth_char(input int i, input logic [4:0] p);
        logic [7:0] c;
        unique case (i)
            0: c = str_char(256'("GET"), 3, p);
            1: c = str_char(256'("POST"), 4, p);
            2: c = str_char(256'("DELETE"), 6, p);
            default: c = str_char(256'("HEAD"), 4, p);
        endcase
        return c;
    endfunction

    function automatic logic [4:0] meth_len(input int i);
        logic [4:0] l;
        unique case (i)
            0: l = 5'd3;
            1: l = 5'd4;
            2: l = 5'd6;
            default: l = 5'd4;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] hdr_char(input int i, input logic [4:0] p);
        logic [7:0] c;
        unique case (i)
            0: c = str_char(256'("Connection: "), 12, p);
            1: c = str_char(256'("Content-Type: "), 14, p);
            default: c = str_char(256'("Content-Length: "), 16, p);
        endcase
        return c;
    endfunction

    function automatic logic [4:0] hdr_len(input int i);
        logic [4:0] l;
        unique case (i)
            0: l = 5'd12;
            1: l = 5'd14;
            default: l = 5'd16;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] typ_char(input int i, input logic [4:0] p);
        logic [7:0] c;
        unique case (i)
            0: c = str_char(256'("text/html"), 9, p);
            1: c = str_char(256'("text/x-php"), 10, p);
            2: c = str_char(256'("text/plain"), 10, p);
            3: c = str_char(256'("image/jpeg"), 10, p);
            4: c = str_char(256'("application/x-python-code"), 25, p);
            5: c = str_char(256'("image/gif"), 9, p);
            default: c = str_char(256'("application/pdf"), 15, p);
        endcase
        return c;
    endfunction

    function automatic logic [4:0] typ_len(input int i);
        logic [4:0] l;
        unique case (i)
            0: l = 5'd9;
            1: l = 5'd10;
            2: l = 5'd10;
            3: l = 5'd10;
            4: l = 5'd25;
            5: l = 5'd9;
            default: l = 5'd15;
        endcase
        return l;
    endfunction

    function automatic logic [3:0] typ_code(input int i);
        logic [3:0] c;
        unique case (i)
            0: c = 4'd2;
            1: c = 4'd3;
            2: c = 4'd1;
            3: c = 4'd5;
            4: c = 4'd4;
            5: c = 4'd6;
            default: c = 4'd7;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ver_char(input logic [4:0] p);
        return str_char(256'("HTTP/1.1"), 8, p);
    endfunction

    function automatic logic [7:0] ka_char(input logic [4:0] p);
        return str_char(256'("keep-alive"), 10, p);
    endfunction

endpackage

// ===== hw/rtl/http_request_header_parser.sv =====
// Channel  | Direction | Handshake             | Payload
// input    | in        | i_valid / o_stall     | i_data_byte, i_end_of_data
// result   | out       | o_valid / i_stall     | o_kind .. o_last
//
// One input byte is taken per cycle. It is parsed in the cycle of its transfer, and its
// results (up to two) are in a two-entry result queue on the next cycle. The parser
// state is one register set. Input stalls while a result waits, unless the last waiting
// result leaves in the same cycle, so with the output side free a byte with one result
// or none keeps one byte per cycle, and a byte with two results stalls until one leaves.
// Reset is synchronous, active low, and returns the parser to the method token with an
// empty queue.
module http_request_header_parser #(
    parameter int URI_LIMIT   = 256,
    parameter int LENGTH_BITS = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [7:0]  o_uri_byte,
    output logic [7:0]  o_uri_length,
    output logic [2:0]  o_status,
    output logic [2:0]  o_method,
    output logic        o_persist,
    output logic [3:0]  o_media_code,
    output logic [30:0] o_body_length,
    output logic        o_last
);

    localparam int UW = $clog2(URI_LIMIT) + 1;
    localparam int RW = 1 + 8 + 8 + 3 + 3 + 1 + 4 + 31 + 1;

    hrhp_pkg::t_phase         r_phase, n_phase;
    logic [4:0]               r_pos, n_pos;
    logic [3:0]               r_mc, n_mc;
    logic [2:0]               r_hc, n_hc;
    logic [6:0]               r_tc, n_tc;
    logic [UW-1:0]            r_uri, n_uri;
    logic [2:0]               r_meth, n_meth;
    logic                     r_keep, n_keep;
    logic [3:0]               r_type, n_type;
    logic [LENGTH_BITS-1:0]   r_len, n_len;

    logic [RW-1:0] r_q [2];
    logic [1:0]    r_cnt;
    logic          r_head;

    logic          accept;
    logic          pop;
    logic [1:0]    n_res;
    logic [RW-1:0] res0, res1;

    // The input is free once the queue is empty or its last entry leaves now.
    assign o_stall = (r_cnt == 2'd2) || (r_cnt == 2'd1 && i_stall);
    assign accept  = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && !i_stall;

    // Summary payload built from a given state snapshot.
    function automatic logic [RW-1:0] summ(input logic [2:0] st, input logic [UW-1:0] uc,
                                           input logic [2:0] m, input logic k,
                                           input logic [3:0] t,
                                           input logic [LENGTH_BITS-1:0] l);
        logic [7:0]  ul;
        logic [30:0] cl;
        logic [63:0] lx;
        ul = (32'(uc) > 32'd255) ? 8'd255 : 8'(uc);
        lx = 64'(l);
        cl = lx[30:0];
        return {1'b1, 8'd0, ul, st, m, k, t, cl, 1'b0};
    endfunction

    // One-byte parse step.
    always_comb begin
        logic [7:0]  b;
        logic        summ0;
        logic [2:0]  st0;
        logic [2:0]  m;
        logic [3:0]  dg;
        logic [LENGTH_BITS+3:0] prod;
        logic        done;
        b = i_data_byte;
        n_phase = r_phase; n_pos = r_pos; n_mc = r_mc; n_hc = r_hc; n_tc = r_tc;
        n_uri = r_uri; n_meth = r_meth; n_keep = r_keep; n_type = r_type; n_len = r_len;
        n_res = 2'd0; res0 = '0; res1 = '0;
        summ0 = 1'b0; st0 = hrhp_pkg::ST_OK; m = 3'd0; done = 1'b0;
        dg = 4'(b - 8'h30);
        prod = (LENGTH_BITS+4)'(r_len) * (LENGTH_BITS+4)'(10) + (LENGTH_BITS+4)'(dg);
        unique case (r_phase)
            hrhp_pkg::PH_METHOD: begin
                if (b == hrhp_pkg::CH_SP) begin
                    if (r_pos != 5'd0) begin
                        for (int i = 3; i >= 0; i--)
                            if (r_mc[i] && hrhp_pkg::meth_len(i) <= r_pos) m = 3'(i + 1);
                        if (m == 3'd0) begin
                            summ0 = 1'b1; st0 = hrhp_pkg::ST_BAD_METH;
                            n_phase = hrhp_pkg::PH_DISCARD;
                        end else begin
                            n_meth = m; n_phase = hrhp_pkg::PH_URI; n_pos = 5'd0;
                        end
                    end
                end else begin
                    for (int i = 0; i < 4; i++)
                        if (r_pos < hrhp_pkg::meth_len(i) && hrhp_pkg::meth_char(i, r_pos) != b)
                            n_mc[i] = 1'b0;
                    if (r_pos != 5'd31) n_pos = r_pos + 5'd1;
                end
            end
            hrhp_pkg::PH_URI: begin
                if (b == hrhp_pkg::CH_SP) begin
                    if (r_uri != '0) begin n_phase = hrhp_pkg::PH_VER; n_pos = 5'd0; end
                end else if (r_uri >= UW'(URI_LIMIT - 1)) begin
                    summ0 = 1'b1; st0 = hrhp_pkg::ST_URI_LONG;
                    n_phase = hrhp_pkg::PH_DISCARD;
                end else begin
                    res0 = '0; res0[RW-2 -: 8] = b; n_res = 2'd1; n_uri = r_uri + UW'(1);
                end
            end
            hrhp_pkg::PH_VER: begin
                if (!(r_pos == 5'd0 && b == hrhp_pkg::CH_LF)) begin
                    if (r_pos >= 5'd8 || hrhp_pkg::ver_char(r_pos) != b) begin
                        summ0 = 1'b1; st0 = hrhp_pkg::ST_BAD_VER;
                        n_phase = hrhp_pkg::PH_DISCARD;
                    end else begin
                        n_pos = r_pos + 5'd1;
                        if (r_pos == 5'd7) n_phase = hrhp_pkg::PH_VREST;
                    end
                end
            end
            hrhp_pkg::PH_VREST, hrhp_pkg::PH_SKIP: begin
                if (b == hrhp_pkg::CH_LF) begin
                    n_phase = hrhp_pkg::PH_HNAME; n_pos = 5'd0; n_hc = 3'b111;
                end
            end
            hrhp_pkg::PH_HNAME: begin
                if (r_pos == 5'd0 && (b == hrhp_pkg::CH_LF || b == hrhp_pkg::CH_CR)) begin
                    summ0 = 1'b1;
                    st0 = (r_meth == hrhp_pkg::M_POST && r_type == hrhp_pkg::CT_NONE) ?
                          hrhp_pkg::ST_POST_TYPE : hrhp_pkg::ST_OK;
                    n_phase = hrhp_pkg::PH_DISCARD;
                end else if (b == hrhp_pkg::CH_LF) begin
                    n_pos = 5'd0; n_hc = 3'b111;
                end else begin
                    for (int i = 0; i < 3; i++)
                        if (r_pos < hrhp_pkg::hdr_len(i) && hrhp_pkg::hdr_char(i, r_pos) != b)
                            n_hc[i] = 1'b0;
                    n_pos = r_pos + 5'd1;
                    if (n_hc[0] && r_pos == 5'd11) begin
                        n_pos = 5'd0; n_phase = hrhp_pkg::PH_CONN;
                    end else if (n_hc[1] && r_pos == 5'd13) begin
                        n_pos = 5'd0; n_phase = hrhp_pkg::PH_TYPE; n_tc = 7'h7F;
                    end else if (n_hc[2] && r_pos == 5'd15) begin
                        n_pos = 5'd0; n_phase = hrhp_pkg::PH_LEN; n_len = '0;
                    end else if (n_hc == 3'd0) begin
                        n_phase = hrhp_pkg::PH_SKIP;
                    end
                end
            end
            hrhp_pkg::PH_CONN: begin
                if (b == hrhp_pkg::CH_LF) begin
                    n_keep = 1'b0; n_phase = hrhp_pkg::PH_HNAME; n_pos = 5'd0; n_hc = 3'b111;
                end else if (r_pos >= 5'd10 || hrhp_pkg::ka_char(r_pos) != b) begin
                    n_keep = 1'b0; n_phase = hrhp_pkg::PH_SKIP;
                end else begin
                    n_pos = r_pos + 5'd1;
                    if (r_pos == 5'd9) n_phase = hrhp_pkg::PH_SKIP;
                end
            end
            hrhp_pkg::PH_TYPE: begin
                if (b == hrhp_pkg::CH_LF) begin
                    n_type = hrhp_pkg::CT_OTHER;
                    n_phase = hrhp_pkg::PH_HNAME; n_pos = 5'd0; n_hc = 3'b111;
                end else begin
                    for (int i = 0; i < 7; i++)
                        if (r_pos < hrhp_pkg::typ_len(i) && hrhp_pkg::typ_char(i, r_pos) != b)
                            n_tc[i] = 1'b0;
                    if (r_pos != 5'd31) n_pos = r_pos + 5'd1;
                    for (int i = 0; i < 7; i++)
                        if (!done && n_tc[i] && hrhp_pkg::typ_len(i) == r_pos + 5'd1) begin
                            n_type = hrhp_pkg::typ_code(i); n_phase = hrhp_pkg::PH_SKIP;
                            done = 1'b1;
                        end
                    if (!done && n_tc == 7'd0) begin
                        n_type = hrhp_pkg::CT_OTHER; n_phase = hrhp_pkg::PH_SKIP;
                    end
                end
            end
            hrhp_pkg::PH_LEN: begin
                if (b >= 8'h30 && b <= 8'h39) begin
                    if (prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
                        summ0 = 1'b1; st0 = hrhp_pkg::ST_LEN_OVF;
                        n_phase = hrhp_pkg::PH_DISCARD;
                    end else begin
                        n_len = prod[LENGTH_BITS-1:0]; n_pos = 5'd1;
                    end
                end else if (r_pos == 5'd0 && (b == hrhp_pkg::CH_SP || b == hrhp_pkg::CH_TAB)) begin
                    n_pos = r_pos;
                end else if (b == hrhp_pkg::CH_LF) begin
                    n_phase = hrhp_pkg::PH_HNAME; n_pos = 5'd0; n_hc = 3'b111;
                end else begin
                    n_phase = hrhp_pkg::PH_SKIP;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        if (summ0) begin
            res0 = summ(st0, n_uri, n_meth, n_keep, n_type, n_len); n_res = 2'd1;
        end
        // End of data: truncation summary unless already discarding, then back to reset state.
        if (i_end_of_data) begin
            if (n_phase != hrhp_pkg::PH_DISCARD) begin
                if (n_res == 2'd0) begin
                    res0 = summ(hrhp_pkg::ST_TRUNC, n_uri, n_meth, n_keep, n_type, n_len);
                    n_res = 2'd1;
                end else begin
                    res1 = summ(hrhp_pkg::ST_TRUNC, n_uri, n_meth, n_keep, n_type, n_len);
                    n_res = 2'd2;
                end
            end
            n_phase = hrhp_pkg::PH_METHOD; n_pos = 5'd0; n_mc = 4'hF; n_hc = 3'b111;
            n_tc = 7'h7F; n_uri = '0; n_meth = 3'd0; n_keep = 1'b1; n_type = 4'd0;
            n_len = '0;
        end
        if (n_res == 2'd1) res0[0] = 1'b1;
        if (n_res == 2'd2) res1[0] = 1'b1;
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hrhp_pkg::PH_METHOD; r_pos <= 5'd0; r_mc <= 4'hF; r_hc <= 3'b111;
            r_tc <= 7'h7F; r_uri <= '0; r_meth <= 3'd0; r_keep <= 1'b1; r_type <= 4'd0;
            r_len <= '0;
        end else if (accept) begin
            r_phase <= n_phase; r_pos <= n_pos; r_mc <= n_mc; r_hc <= n_hc; r_tc <= n_tc;
            r_uri <= n_uri; r_meth <= n_meth; r_keep <= n_keep; r_type <= n_type;
            r_len <= n_len;
        end
    end

    // Result queue: refilled when empty or when its last entry leaves, drained one
    // transfer a cycle while the output is not stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0; r_head <= 1'b0;
        end else if (accept) begin
            r_cnt <= n_res; r_head <= 1'b0;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1; r_head <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[0] <= res0; r_q[1] <= res1;
        end
    end

    assign {o_kind, o_uri_byte, o_uri_length, o_status, o_method, o_persist,
            o_media_code, o_body_length, o_last} = r_q[r_head];

endmodule

// ===== hw/rtl/hrhp_checker.sv =====
module hrhp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_kind,
    input logic [7:0] o_uri_byte,
    input logic [2:0] o_status,
    input logic       o_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_uri_byte) && $stable(o_last))
        else $error("stalled result changed");
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_kind |-> o_status == 3'd0)
        else $error("URI byte result with status");
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> o_last)
        else $error("summary not last");
    a_byte_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> o_uri_byte == 8'd0)
        else $error("summary with URI byte");
    a_empty_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with nothing waiting");
endmodule

bind http_request_header_parser hrhp_checker u_hrhp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_kind(o_kind), .o_uri_byte(o_uri_byte),
    .o_status(o_status), .o_last(o_last)
);
